@@ src/bpm_pkg.sv @@
// shared types and constants of the byte pair merge engine
`default_nettype none
package bpm_pkg;
	localparam int TOK_W = 16;
	localparam int MAX_PIECE = 64;
	localparam int PIDX_W = 6;
	localparam int PLEN_W = 7;
	localparam int MIDX_W = 13;
	localparam int MCNT_W = 14;
	localparam int MERGE_DEPTH = 8192;
	localparam logic [15:0] RANK_NEVER = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_MAP = 2'd0,
		CMD_MERGE = 2'd1,
		CMD_BYTE = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAPRD,
		ST_MAPWR,
		ST_PAIR,
		ST_SRCH,
		ST_SRCHW,
		ST_CHECK,
		ST_CHECKW,
		ST_REWR,
		ST_REWRW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take_cmd;
		logic map_rd;
		logic buf_push;
		logic scan_start;
		logic pair_load;
		logic srch_start;
		logic srch_step;
		logic check_rd;
		logic check_eval;
		logic next_pair;
		logic rewr_start;
		logic rewr_rd;
		logic rewr_step;
		logic emit_start;
		logic emit_rd;
		logic emit_pop;
	} cmd_bus_t;

	typedef struct packed {
		logic last_byte;
		logic is_byte;
		logic pair_done;
		logic srch_done;
		logic found_any;
		logic rewr_done;
		logic emit_done;
	} stat_bus_t;
endpackage
`default_nettype wire

@@ src/bpe_piece_merger_top.sv @@
// top level of the byte pair merge engine
// operation: a byte is mapped through the byte map and pushed; a last byte starts merge
// rounds, each a binary search of the merge table per adjacent pair and a write-back of the piece
// output: results leave one token at a time, held while out_ready is low; one piece at a time
// reset: asynchronous, clears control and length; tables hold until written
`default_nettype none
module bpe_piece_merger_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [12:0] entry_index,
	input  wire logic [15:0] token_id,
	input  wire logic [15:0] left_id,
	input  wire logic [15:0] right_id,
	input  wire logic [15:0] rank,
	input  wire logic [7:0] byte_value,
	input  wire logic last,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [15:0] out_token,
	output logic out_last,
	output logic overflow,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [13:0] cfg_data
);
	import bpm_pkg::*;

	cmd_bus_t cb;
	stat_bus_t sb;
	logic [MCNT_W-1:0] mc_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mc_q <= '0;
		else if (cfg_valid) mc_q <= cfg_data;
	end

	bpm_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sb, .cb);
	bpm_datapath u_dp (.clk, .arst_n, .cb, .sb, .cmd, .entry_index, .token_id,
		.left_id, .right_id, .rank, .byte_value, .last, .rule_cnt(mc_q),
		.out_token, .out_last, .overflow);
endmodule
`default_nettype wire

@@ src/bpm_datapath.sv @@
// datapath: byte map, merge table, piece buffer, search and rewrite
`default_nettype none
module bpm_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire bpm_pkg::cmd_bus_t cb,
	output bpm_pkg::stat_bus_t sb,
	input  wire logic [1:0] cmd,
	input  wire logic [12:0] entry_index,
	input  wire logic [15:0] token_id,
	input  wire logic [15:0] left_id,
	input  wire logic [15:0] right_id,
	input  wire logic [15:0] rank,
	input  wire logic [7:0] byte_value,
	input  wire logic last,
	input  wire logic [bpm_pkg::MCNT_W-1:0] rule_cnt,
	output logic [15:0] out_token,
	output logic out_last,
	output logic overflow
);
	import bpm_pkg::*;

	logic [TOK_W-1:0] map_mem [256];
	logic [63:0] mt_mem [MERGE_DEPTH];
	logic [TOK_W-1:0] buf_mem [MAX_PIECE];
	logic [63:0] mt_rd_q;
	logic [TOK_W-1:0] map_rd_q;
	logic [PLEN_W-1:0] len_q;
	logic ovf_q, last_q;
	logic [PIDX_W-1:0] i_q;
	logic [MCNT_W-1:0] lo_q, hi_q, n_eff;
	logic [MIDX_W-1:0] rd_addr;
	logic [TOK_W-1:0] a_q, b_q;
	logic [15:0] best_q;
	logic [47:0] pick_q;
	logic found_q;
	logic [PLEN_W-1:0] rd_q, wr_q, emit_q;
	logic [MCNT_W-1:0] mid;
	logic [31:0] key, mkey;
	logic [1:0] cmd_l;
	logic [PLEN_W-1:0] ip1;
	logic [PIDX_W-1:0] ra0, ra1;
	logic rewr_hit, rewr_fin;

	assign n_eff = (rule_cnt > MCNT_W'(MERGE_DEPTH)) ? MCNT_W'(MERGE_DEPTH) : rule_cnt;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign key = {a_q, b_q};
	assign mkey = {mt_rd_q[63:48], mt_rd_q[47:32]};
	assign cmd_l = cmd;
	assign ip1 = {1'b0, i_q} + PLEN_W'(1);
	assign rd_addr = cb.check_rd ? lo_q[MIDX_W-1:0] : mid[MIDX_W-1:0];

	// buffer read port: pair scan, rewrite and emit share two registered reads
	assign ra0 = cb.rewr_rd ? rd_q[PIDX_W-1:0] : (cb.emit_rd ? emit_q[PIDX_W-1:0] : i_q);
	assign ra1 = ra0 + PIDX_W'(1);
	assign rewr_hit = (rd_q + PLEN_W'(1) < len_q) && a_q == pick_q[47:32]
		&& b_q == pick_q[31:16];
	assign rewr_fin = cb.rewr_step && (rewr_hit ? (rd_q + PLEN_W'(2) >= len_q)
		: (rd_q + PLEN_W'(1) >= len_q));

	always_ff @(posedge clk) begin
		if (cb.take_cmd && cmd_l == CMD_MAP && entry_index < 13'd256)
			map_mem[entry_index[7:0]] <= token_id;
		if (cb.take_cmd && cmd_l == CMD_MERGE)
			mt_mem[entry_index] <= {left_id, right_id, token_id, rank};
		if (cb.map_rd) map_rd_q <= map_mem[byte_value];
		mt_rd_q <= mt_mem[rd_addr];
	end

	// piece buffer: pushes, pair reads and in-place compaction
	always_ff @(posedge clk) begin
		if (cb.buf_push && len_q < PLEN_W'(MAX_PIECE))
			buf_mem[len_q[PIDX_W-1:0]] <= map_rd_q;
		if (cb.rewr_step)
			buf_mem[wr_q[PIDX_W-1:0]] <= rewr_hit ? pick_q[15:0] : a_q;
		if (cb.pair_load || cb.rewr_rd || cb.emit_rd) begin
			a_q <= buf_mem[ra0];
			b_q <= buf_mem[ra1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; ovf_q <= 1'b0; last_q <= 1'b0; i_q <= '0;
			lo_q <= '0; hi_q <= '0; best_q <= RANK_NEVER; pick_q <= '0;
			found_q <= 1'b0; rd_q <= '0; wr_q <= '0; emit_q <= '0;
		end else begin
			if (cb.take_cmd) last_q <= last;
			if (cb.buf_push) begin
				if (len_q < PLEN_W'(MAX_PIECE)) len_q <= len_q + PLEN_W'(1);
				else ovf_q <= 1'b1;
			end
			if (cb.scan_start) begin
				i_q <= '0; best_q <= RANK_NEVER; found_q <= 1'b0;
			end
			if (cb.srch_start) begin
				lo_q <= '0; hi_q <= n_eff;
			end
			if (cb.srch_step) begin
				if (mkey < key) lo_q <= mid + MCNT_W'(1);
				else hi_q <= mid;
			end
			if (cb.check_eval && lo_q < n_eff && mkey == key && mt_rd_q[15:0] < best_q) begin
				best_q <= mt_rd_q[15:0]; pick_q <= mt_rd_q[63:16]; found_q <= 1'b1;
			end
			if (cb.next_pair) i_q <= i_q + PIDX_W'(1);
			if (cb.rewr_start) begin
				rd_q <= '0; wr_q <= '0;
			end
			if (cb.rewr_step) begin
				if (rewr_hit) rd_q <= rd_q + PLEN_W'(2);
				else rd_q <= rd_q + PLEN_W'(1);
				wr_q <= wr_q + PLEN_W'(1);
				if (rewr_fin) len_q <= wr_q + PLEN_W'(1);
			end
			if (cb.emit_start) emit_q <= '0;
			if (cb.emit_pop) begin
				if (emit_q + PLEN_W'(1) >= len_q) begin
					emit_q <= '0; len_q <= '0; ovf_q <= 1'b0;
				end else emit_q <= emit_q + PLEN_W'(1);
			end
		end
	end

	always_comb begin
		sb.last_byte = last_q;
		sb.is_byte = (cmd_l == CMD_BYTE);
		sb.pair_done = (ip1 + PLEN_W'(1) > len_q) || (len_q < PLEN_W'(2));
		sb.srch_done = !(lo_q < hi_q);
		sb.found_any = found_q;
		sb.rewr_done = rewr_fin;
		sb.emit_done = (emit_q + PLEN_W'(1) >= len_q);
	end

	assign out_token = a_q;
	assign out_last = (emit_q + PLEN_W'(1) >= len_q);
	assign overflow = ovf_q;

	// compacted length never exceeds buffer
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= PLEN_W'(MAX_PIECE)) else $error("piece length out of range");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cb.rewr_step |-> wr_q <= rd_q) else $error("write passed read");
	a_srch: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= MCNT_W'(MERGE_DEPTH)) else $error("search bound");
endmodule
`default_nettype wire

@@ src/bpm_ctrl.sv @@
// controller state machine of the merge engine
`default_nettype none
module bpm_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire bpm_pkg::stat_bus_t sb,
	output bpm_pkg::cmd_bus_t cb
);
	import bpm_pkg::*;

	state_t st_q, st_d;
	logic emit_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// out_token is a registered buffer read: out_valid is registered to match and drops after each token is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_vld_q <= 1'b0;
		else if (st_q != ST_EMIT || (out_valid && out_ready)) emit_vld_q <= 1'b0;
		else emit_vld_q <= 1'b1;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_valid) st_d = sb.is_byte ? ST_MAPRD : ST_IDLE;
			ST_MAPRD: st_d = ST_MAPWR;
			ST_MAPWR: st_d = sb.last_byte ? ST_PAIR : ST_IDLE;
			ST_PAIR: st_d = sb.pair_done ? (sb.found_any ? ST_REWR : ST_EMIT) : ST_SRCH;
			ST_SRCH: st_d = sb.srch_done ? ST_CHECK : ST_SRCHW;
			ST_SRCHW: st_d = ST_SRCH;
			ST_CHECK: st_d = ST_CHECKW;
			ST_CHECKW: st_d = ST_PAIR;
			ST_REWR: st_d = ST_REWRW;
			ST_REWRW: st_d = sb.rewr_done ? ST_PAIR : ST_REWR;
			ST_EMIT: if (out_valid && out_ready && sb.emit_done) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cb = '0;
		in_ready = (st_q == ST_IDLE);
		out_valid = emit_vld_q;
		unique case (st_q)
			ST_IDLE: begin
				cb.take_cmd = in_valid;
				cb.map_rd = in_valid;
			end
			ST_MAPWR: begin
				cb.buf_push = 1'b1;
				cb.scan_start = sb.last_byte;
			end
			ST_PAIR: begin
				cb.pair_load = !sb.pair_done;
				cb.srch_start = !sb.pair_done;
				cb.rewr_start = sb.pair_done && sb.found_any;
				cb.emit_start = sb.pair_done && !sb.found_any;
			end
			ST_SRCHW: cb.srch_step = 1'b1;
			ST_CHECK: cb.check_rd = 1'b1;
			ST_CHECKW: begin
				cb.check_eval = 1'b1;
				cb.next_pair = 1'b1;
			end
			ST_REWR: cb.rewr_rd = 1'b1;
			ST_REWRW: begin
				cb.rewr_step = 1'b1;
				cb.scan_start = sb.rewr_done;
			end
			ST_EMIT: begin
				cb.emit_rd = 1'b1;
				cb.emit_pop = out_valid && out_ready;
			end
			default: ;
		endcase
	end

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while emitting");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == ST_EMIT) else $error("result outside emit");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid) else $error("result repeated");
endmodule
`default_nettype wire
